/* sv/dnh_pkg.sv */
// shared constants, types and character/fold functions for the dns name hash
package dnh_pkg;

  localparam int BUCKET_BITS  = 10;
  localparam int SHORT_PERIOD = BUCKET_BITS - 5;
  localparam int CHECK_PERIOD = 25;

  localparam int CHAR_W   = 8;
  localparam int CODE_W   = 6;
  localparam int SUM_W    = 24;
  localparam int CHECK_W  = 32;
  localparam int SHORT_W  = $clog2(SHORT_PERIOD + 1);
  localparam int LONG_W   = $clog2(CHECK_PERIOD + 1);
  localparam int IN_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = BUCKET_BITS + CHECK_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  localparam logic [CODE_W-1:0] CODE_DIGIT0     = CODE_W'(26);
  localparam logic [CODE_W-1:0] CODE_DOT        = CODE_W'(36);
  localparam logic [CODE_W-1:0] CODE_HYPHEN     = CODE_W'(37);
  localparam logic [CODE_W-1:0] CODE_UNDERSCORE = CODE_W'(38);
  localparam logic [CODE_W-1:0] CODE_OTHER      = CODE_W'(38);
  localparam logic [CODE_W-1:0] CODE_OTHER_US   = CODE_W'(39);

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_HYPHEN  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_USCORE  = 8'h5F;

  typedef struct packed {
    logic [BUCKET_BITS-1:0] bucket_hash;
    logic [CHECK_W-1:0]     check_hash;
  } dnh_result_t;

  // case-insensitive alphabet code of one name byte
  function automatic logic [CODE_W-1:0] map_char(input logic [CHAR_W-1:0] c,
                                                 input logic us_en);
    logic [CODE_W-1:0] code;
    case (c) inside
      [CH_UPPER_A:CH_UPPER_Z]: code = CODE_W'(c - CH_UPPER_A);
      [CH_LOWER_A:CH_LOWER_Z]: code = CODE_W'(c - CH_LOWER_A);
      [CH_ZERO:CH_NINE]:       code = CODE_DIGIT0 + CODE_W'(c - CH_ZERO);
      CH_DOT:                  code = CODE_DOT;
      CH_HYPHEN:               code = CODE_HYPHEN;
      CH_USCORE:               code = us_en ? CODE_UNDERSCORE : CODE_OTHER;
      default:                 code = us_en ? CODE_OTHER_US : CODE_OTHER;
    endcase
    return code;
  endfunction

  // two end-around folds of the bucket sum down to BUCKET_BITS
  function automatic logic [BUCKET_BITS-1:0] fold_bucket(input logic [SUM_W-1:0] acc);
    logic [SUM_W:0] f1;
    logic [SUM_W:0] f2;
    f1 = (SUM_W+1)'(acc[BUCKET_BITS-1:0]) + (SUM_W+1)'(acc >> BUCKET_BITS);
    f2 = (SUM_W+1)'(f1[BUCKET_BITS-1:0]) + (f1 >> BUCKET_BITS);
    return f2[BUCKET_BITS-1:0];
  endfunction

endpackage

/* sv/dnh_core.sv */
// running bucket and check sums with position counters
module dnh_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [dnh_pkg::CHAR_W-1:0]  char_code,
  input  logic                        last_char,
  input  logic                        us_en,
  output dnh_pkg::dnh_result_t        result
);
  import dnh_pkg::*;

  logic [SUM_W-1:0]   bucket_sum_r, bucket_sum_nxt;
  logic [CHECK_W-1:0] check_sum_r, check_sum_nxt;
  logic [SHORT_W-1:0] short_cnt_r, short_cnt_nxt;
  logic [LONG_W-1:0]  long_cnt_r, long_cnt_nxt;
  logic [CODE_W-1:0]  code;

  always_comb begin
    code           = map_char(char_code, us_en);
    bucket_sum_nxt = bucket_sum_r + (SUM_W'(code) << short_cnt_r);
    check_sum_nxt  = check_sum_r + (CHECK_W'(code) << long_cnt_r);
    short_cnt_nxt  = (short_cnt_r == SHORT_W'(SHORT_PERIOD - 1)) ? '0 : short_cnt_r + 1'b1;
    long_cnt_nxt   = (long_cnt_r == LONG_W'(CHECK_PERIOD - 1)) ? '0 : long_cnt_r + 1'b1;
    result.bucket_hash = fold_bucket(bucket_sum_nxt);
    result.check_hash  = check_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_sum_r <= '0;
      check_sum_r  <= '0;
      short_cnt_r  <= '0;
      long_cnt_r   <= '0;
    end else if (step) begin
      // the last byte of a name starts the next one from zero
      if (last_char) begin
        bucket_sum_r <= '0;
        check_sum_r  <= '0;
        short_cnt_r  <= '0;
        long_cnt_r   <= '0;
      end else begin
        bucket_sum_r <= bucket_sum_nxt;
        check_sum_r  <= check_sum_nxt;
        short_cnt_r  <= short_cnt_nxt;
        long_cnt_r   <= long_cnt_nxt;
      end
    end
  end

endmodule

/* sv/dns_name_dual_hash_top.sv */
// top level of the dns name dual hash: input stage, hash core, output register
//
//  channel | dir | ports                                   | contents
//  in      | in  | in_tvalid in_tready in_tdata in_tlast   | one name byte, tlast on final byte
//  out     | out | out_tvalid out_tready out_tdata         | bucket and check hash per name
//  cfg     | in  | cfg_wr_en cfg_wr_data                   | underscore_enable
//
// one byte per cycle unless the input stage waits; a byte goes through the
// input register and hash core; a final byte's result loads out_tvalid/out_tdata.
// the input stage only waits when it holds a final byte and the output
// register is full and not being taken. reset clears sums, counters, valids
// and underscore_enable.
module dns_name_dual_hash_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dnh_pkg::IN_TDATA_W-1:0]   in_tdata,   // char_code
  input  logic                             in_tlast,   // last_char
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dnh_pkg::OUT_TDATA_W-1:0]  out_tdata,  // bucket_hash, check_hash, zero pad
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data // underscore_enable
);
  import dnh_pkg::*;

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;
  logic              us_en_r;
  logic              out_valid_r;
  dnh_result_t       out_data_r;
  dnh_result_t       core_result;
  logic              advance;

  // a non-final byte never needs the output register
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  dnh_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .us_en     (us_en_r),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      us_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata[CHAR_W-1:0];
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_data_r <= core_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_data_r.check_hash, out_data_r.bucket_hash});

endmodule
